// ===== rtl/qlsf_pkg.sv =====
package qlsf_pkg;

   // Datapath widths
   localparam int WIDE_W   = 256;
   localparam int MUL_W    = 64;
   localparam int CNT_W    = $clog2(WIDE_W);

   // Item fields
   localparam int X_W        = 12;
   localparam int Y_W        = 16;
   localparam int COEF_W     = 64;
   localparam int POINTS_W   = 11;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 208;

   // Defaults for the top-level parameters
   localparam int MAX_POINTS_DEF = 1024;
   localparam int FRAC_BITS_DEF  = 16;

   // Per-sample products, signed
   localparam int X2_W  = 24;
   localparam int X3_W  = 34;
   localparam int X4_W  = 46;
   localparam int XY_W  = 28;
   localparam int X2Y_W = 39;

   // Running sums, signed
   localparam int SX_W   = 23;
   localparam int SX2_W  = 34;
   localparam int SX3_W  = 45;
   localparam int SX4_W  = 56;
   localparam int SY_W   = 27;
   localparam int SXY_W  = 38;
   localparam int SX2Y_W = 49;

   // Scratch memory for the solve
   localparam int RAM_DEPTH = 16;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam logic [RAM_AW-1:0] ADR_M24 = RAM_AW'(0);
   localparam logic [RAM_AW-1:0] ADR_M14 = RAM_AW'(1);
   localparam logic [RAM_AW-1:0] ADR_M13 = RAM_AW'(2);
   localparam logic [RAM_AW-1:0] ADR_P   = RAM_AW'(3);
   localparam logic [RAM_AW-1:0] ADR_Q   = RAM_AW'(4);
   localparam logic [RAM_AW-1:0] ADR_R   = RAM_AW'(5);
   localparam logic [RAM_AW-1:0] ADR_U   = RAM_AW'(6);
   localparam logic [RAM_AW-1:0] ADR_N0  = RAM_AW'(7);

   // Microcode sequence
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_SAMPLE_LAST = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_SOLVE_LAST  = STEP_W'(30);
   localparam logic [CNT_W-1:0]  SAMPLE_MSB       = CNT_W'(23);
   localparam logic [CNT_W-1:0]  SOLVE_MSB        = CNT_W'(MUL_W - 1);

   typedef enum logic [1:0] {
      FIT_OK,
      FIT_SINGULAR,
      FIT_TOO_MANY,
      FIT_SATURATED
   } fit_status_type;

   typedef enum logic [3:0] {
      SRC_CNT, SRC_SX, SRC_SX2, SRC_SX3, SRC_SX4, SRC_SY, SRC_SXY, SRC_SX2Y,
      SRC_X, SRC_Y, SRC_X2, SRC_MEM
   } src_type;

   typedef enum logic [2:0] {
      DST_NONE, DST_X2, DST_X3, DST_X4, DST_XY, DST_X2Y, DST_DET, DST_MEM
   } dst_type;

   typedef enum logic {
      OP_MAC,
      OP_DIV
   } alu_op_type;

   typedef enum logic [2:0] {
      AL_IDLE, AL_MAC, AL_ABSN, AL_ABSD, AL_DIV, AL_RND, AL_INC
   } alu_state_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_LOAD, ST_WAIT, ST_SUMS, ST_CHECK,
      ST_DFETCH, ST_DLOAD, ST_DWAIT, ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      src_type           src_a;
      src_type           src_b;
      logic              first;
      logic              neg;
      dst_type           dst;
      logic [RAM_AW-1:0] raddr;
      logic [RAM_AW-1:0] waddr;
   } step_type;

   typedef struct packed {
      logic             start;
      alu_op_type       op;
      logic             first;
      logic             neg;
      logic [CNT_W-1:0] last_bit;
   } alu_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              qneg;
      logic [WIDE_W-1:0] acc;
      logic [WIDE_W-1:0] quo;
   } alu_stat_type;

   function automatic step_type mk_step(input src_type a, input src_type b, input logic first,
                                        input logic neg, input dst_type dst,
                                        input logic [RAM_AW-1:0] raddr,
                                        input logic [RAM_AW-1:0] waddr);
      step_type s;
      s.src_a = a;
      s.src_b = b;
      s.first = first;
      s.neg   = neg;
      s.dst   = dst;
      s.raddr = raddr;
      s.waddr = waddr;
      return s;
   endfunction

   // Each step adds (or subtracts) src_a * src_b to the accumulator.
   function automatic step_type ucode(input logic [STEP_W-1:0] idx);
      step_type s;
      case (idx)
         // per-sample products
         5'd0:  s = mk_step(SRC_X,    SRC_X,    1'b1, 1'b0, DST_X2,   ADR_M24, ADR_M24);
         5'd1:  s = mk_step(SRC_X2,   SRC_X,    1'b1, 1'b0, DST_X3,   ADR_M24, ADR_M24);
         5'd2:  s = mk_step(SRC_X2,   SRC_X2,   1'b1, 1'b0, DST_X4,   ADR_M24, ADR_M24);
         5'd3:  s = mk_step(SRC_Y,    SRC_X,    1'b1, 1'b0, DST_XY,   ADR_M24, ADR_M24);
         5'd4:  s = mk_step(SRC_X2,   SRC_Y,    1'b1, 1'b0, DST_X2Y,  ADR_M24, ADR_M24);
         // 2x2 minors of the normal matrix
         5'd5:  s = mk_step(SRC_SX4,  SRC_SX2,  1'b1, 1'b0, DST_NONE, ADR_M24, ADR_M24);
         5'd6:  s = mk_step(SRC_SX3,  SRC_SX3,  1'b0, 1'b1, DST_MEM,  ADR_M24, ADR_M24);
         5'd7:  s = mk_step(SRC_SX4,  SRC_SX,   1'b1, 1'b0, DST_NONE, ADR_M24, ADR_M14);
         5'd8:  s = mk_step(SRC_SX3,  SRC_SX2,  1'b0, 1'b1, DST_MEM,  ADR_M24, ADR_M14);
         5'd9:  s = mk_step(SRC_SX3,  SRC_SX,   1'b1, 1'b0, DST_NONE, ADR_M24, ADR_M13);
         5'd10: s = mk_step(SRC_SX2,  SRC_SX2,  1'b0, 1'b1, DST_MEM,  ADR_M24, ADR_M13);
         // determinant
         5'd11: s = mk_step(SRC_MEM,  SRC_CNT,  1'b1, 1'b0, DST_NONE, ADR_M24, ADR_M24);
         5'd12: s = mk_step(SRC_MEM,  SRC_SX,   1'b0, 1'b1, DST_NONE, ADR_M14, ADR_M24);
         5'd13: s = mk_step(SRC_MEM,  SRC_SX2,  1'b0, 1'b0, DST_DET,  ADR_M13, ADR_M24);
         // minors that involve the right-hand side
         5'd14: s = mk_step(SRC_SX4,  SRC_SXY,  1'b1, 1'b0, DST_NONE, ADR_M24, ADR_P);
         5'd15: s = mk_step(SRC_SX3,  SRC_SX2Y, 1'b0, 1'b1, DST_MEM,  ADR_M24, ADR_P);
         5'd16: s = mk_step(SRC_SX3,  SRC_SXY,  1'b1, 1'b0, DST_NONE, ADR_M24, ADR_Q);
         5'd17: s = mk_step(SRC_SX2,  SRC_SX2Y, 1'b0, 1'b1, DST_MEM,  ADR_M24, ADR_Q);
         5'd18: s = mk_step(SRC_SX2Y, SRC_SX,   1'b1, 1'b0, DST_NONE, ADR_M24, ADR_R);
         5'd19: s = mk_step(SRC_SXY,  SRC_SX2,  1'b0, 1'b1, DST_MEM,  ADR_M24, ADR_R);
         5'd20: s = mk_step(SRC_SX2Y, SRC_SX2,  1'b1, 1'b0, DST_NONE, ADR_M24, ADR_U);
         5'd21: s = mk_step(SRC_SXY,  SRC_SX3,  1'b0, 1'b1, DST_MEM,  ADR_M24, ADR_U);
         // numerators
         5'd22: s = mk_step(SRC_MEM,  SRC_SY,   1'b1, 1'b0, DST_NONE, ADR_M24, ADR_N0);
         5'd23: s = mk_step(SRC_MEM,  SRC_SX,   1'b0, 1'b1, DST_NONE, ADR_P,   ADR_N0);
         5'd24: s = mk_step(SRC_MEM,  SRC_SX2,  1'b0, 1'b0, DST_MEM,  ADR_Q,   ADR_N0);
         5'd25: s = mk_step(SRC_MEM,  SRC_CNT,  1'b1, 1'b0, DST_NONE, ADR_P,   ADR_N0);
         5'd26: s = mk_step(SRC_MEM,  SRC_SY,   1'b0, 1'b1, DST_NONE, ADR_M14, ADR_N0);
         5'd27: s = mk_step(SRC_MEM,  SRC_SX2,  1'b0, 1'b0, DST_MEM,  ADR_R,
                            RAM_AW'(ADR_N0 + RAM_AW'(1)));
         5'd28: s = mk_step(SRC_MEM,  SRC_CNT,  1'b1, 1'b0, DST_NONE, ADR_U,   ADR_N0);
         5'd29: s = mk_step(SRC_MEM,  SRC_SX,   1'b0, 1'b1, DST_NONE, ADR_R,   ADR_N0);
         5'd30: s = mk_step(SRC_MEM,  SRC_SY,   1'b0, 1'b0, DST_MEM,  ADR_M13,
                            RAM_AW'(ADR_N0 + RAM_AW'(2)));
         default: s = mk_step(SRC_CNT, SRC_CNT, 1'b1, 1'b0, DST_NONE, ADR_M24, ADR_M24);
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/quadratic_least_squares_fit.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tdata: x_value, y_value; tlast: last_point
// rsp      out        rsp_tvalid/tready     tdata: coefficients, points_used, fit_status
//
// Each sample runs five products on one bit-serial shared multiply-accumulate
// unit, each with fetch and write-back, and then adds them into the sums. A
// sample marked last then runs the solve: 26 multiply-accumulate steps and
// three 256-bit divisions at one quotient bit per cycle, all on that same unit.
// Reset is synchronous and clears the sums and the control state. The block
// takes no transaction while it works or while a result waits on rsp.
module quadratic_least_squares_fit #(
   parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS  = qlsf_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [11:0] x_value, [27:12] y_value, [31:28] zero
   input  logic [qlsf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [63:0] coef_const, [127:64] coef_linear, [191:128] coef_square,
   // [202:192] points_used, [204:203] fit_status, [207:205] zero
   output logic [qlsf_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import qlsf_pkg::*;

   localparam logic [POINTS_W-1:0] MAX_CNT = POINTS_W'(MAX_POINTS);

   ctrl_state_type              state_ff, state_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [1:0]                  didx_ff, didx_in;
   logic signed [X_W-1:0]       x_ff, x_in;
   logic signed [Y_W-1:0]       y_ff, y_in;
   logic                        last_ff, last_in;
   logic signed [X2_W-1:0]      x2_ff, x2_in;
   logic signed [X3_W-1:0]      x3_ff, x3_in;
   logic signed [X4_W-1:0]      x4_ff, x4_in;
   logic signed [XY_W-1:0]      xy_ff, xy_in;
   logic signed [X2Y_W-1:0]     x2y_ff, x2y_in;
   logic signed [SX_W-1:0]      sum_x_ff, sum_x_in;
   logic signed [SX2_W-1:0]     sum_x2_ff, sum_x2_in;
   logic signed [SX3_W-1:0]     sum_x3_ff, sum_x3_in;
   logic signed [SX4_W-1:0]     sum_x4_ff, sum_x4_in;
   logic signed [SY_W-1:0]      sum_y_ff, sum_y_in;
   logic signed [SXY_W-1:0]     sum_xy_ff, sum_xy_in;
   logic signed [SX2Y_W-1:0]    sum_x2y_ff, sum_x2y_in;
   logic [POINTS_W-1:0]         count_ff, count_in;
   logic                        overflow_ff, overflow_in;
   logic                        singular_ff, singular_in;
   logic                        sat_ff, sat_in;
   logic [WIDE_W-1:0]           det_ff, det_in;
   logic [COEF_W-1:0]           coef0_ff, coef0_in;
   logic [COEF_W-1:0]           coef1_ff, coef1_in;
   logic [COEF_W-1:0]           coef2_ff, coef2_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;

   step_type                    cur;
   logic                        accept, full, alu_done;
   logic                        ram_we;
   logic [RAM_AW-1:0]           ram_raddr;
   logic [WIDE_W-1:0]           ram_rdata;
   alu_cmd_type                 alu_cmd;
   alu_stat_type                alu_stat;
   logic [WIDE_W-1:0]           opa, opd, opb_full;
   logic [MUL_W-1:0]            opb;
   logic [COEF_W-1:0]           mag, coef_val;
   logic                        hi_nz, coef_sat;
   fit_status_type              status;
   logic [COEF_W-1:0]           out0, out1, out2;

   assign cur      = ucode(step_ff);
   assign accept   = req_tvalid & req_tready;
   assign full     = (count_ff >= MAX_CNT);
   assign alu_done = ~alu_stat.busy;

   // Sign-extended view of a running sum, a sample or a sample product; the point count is zero-extended.
   function automatic logic [WIDE_W-1:0] src_value(input src_type s);
      logic [WIDE_W-1:0] v;
      case (s)
         SRC_CNT:  v = WIDE_W'(count_ff);
         SRC_SX:   v = WIDE_W'(sum_x_ff);
         SRC_SX2:  v = WIDE_W'(sum_x2_ff);
         SRC_SX3:  v = WIDE_W'(sum_x3_ff);
         SRC_SX4:  v = WIDE_W'(sum_x4_ff);
         SRC_SY:   v = WIDE_W'(sum_y_ff);
         SRC_SXY:  v = WIDE_W'(sum_xy_ff);
         SRC_SX2Y: v = WIDE_W'(sum_x2y_ff);
         SRC_X:    v = WIDE_W'(x_ff);
         SRC_Y:    v = WIDE_W'(y_ff);
         SRC_X2:   v = WIDE_W'(x2_ff);
         default:  v = '0;
      endcase
      return v;
   endfunction

   // Operand selection for the shared unit.
   always_comb begin
      if (state_ff == ST_DLOAD) begin
         opa = ram_rdata << FRAC_BITS;
      end else if (cur.src_a == SRC_MEM) begin
         opa = ram_rdata;
      end else begin
         opa = src_value(cur.src_a);
      end
      opb_full = src_value(cur.src_b);
      opb      = opb_full[MUL_W-1:0];
      opd      = det_ff;
   end

   assign ram_raddr = (state_ff == ST_DFETCH) ? RAM_AW'(ADR_N0 + RAM_AW'(didx_ff)) : cur.raddr;

   // Rounded quotient magnitude to a saturated signed coefficient.
   always_comb begin
      mag   = alu_stat.quo[COEF_W-1:0];
      hi_nz = |alu_stat.quo[WIDE_W-1:COEF_W];
      if (!alu_stat.qneg) begin
         coef_sat = hi_nz | mag[COEF_W-1];
         coef_val = coef_sat ? {1'b0, {(COEF_W-1){1'b1}}} : mag;
      end else begin
         coef_sat = hi_nz | (mag[COEF_W-1] & (|mag[COEF_W-2:0]));
         coef_val = coef_sat ? {1'b1, {(COEF_W-1){1'b0}}} : (~mag + COEF_W'(1));
      end
   end

   always_comb begin
      if (overflow_ff) begin
         status = FIT_TOO_MANY;
      end else if (singular_ff) begin
         status = FIT_SINGULAR;
      end else if (sat_ff) begin
         status = FIT_SATURATED;
      end else begin
         status = FIT_OK;
      end
      out0 = (overflow_ff | singular_ff) ? '0 : coef0_ff;
      out1 = (overflow_ff | singular_ff) ? '0 : coef1_ff;
      out2 = (overflow_ff | singular_ff) ? '0 : coef2_ff;
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full) begin
                  state_in = req_tlast ? ST_EMIT : ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (alu_done) begin
               if (step_ff == STEP_SAMPLE_LAST) begin
                  state_in = ST_SUMS;
               end else if (step_ff == STEP_SOLVE_LAST) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SUMS:   state_in = last_ff ? ST_FETCH : ST_IDLE;
         ST_CHECK:  state_in = (det_ff == '0) ? ST_EMIT : ST_DFETCH;
         ST_DFETCH: state_in = ST_DLOAD;
         ST_DLOAD:  state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (alu_done) begin
               state_in = (didx_ff == 2'd2) ? ST_EMIT : ST_DFETCH;
            end
         end
         ST_EMIT:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and handshake outputs of the sequencer.
   always_comb begin
      step_in      = step_ff;
      didx_in      = didx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      x2_in        = x2_ff;
      x3_in        = x3_ff;
      x4_in        = x4_ff;
      xy_in        = xy_ff;
      x2y_in       = x2y_ff;
      sum_x_in     = sum_x_ff;
      sum_x2_in    = sum_x2_ff;
      sum_x3_in    = sum_x3_ff;
      sum_x4_in    = sum_x4_ff;
      sum_y_in     = sum_y_ff;
      sum_xy_in    = sum_xy_ff;
      sum_x2y_in   = sum_x2y_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      singular_in  = singular_ff;
      sat_in       = sat_ff;
      det_in       = det_ff;
      coef0_in     = coef0_ff;
      coef1_in     = coef1_ff;
      coef2_in     = coef2_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      ram_we       = 1'b0;
      alu_cmd      = '0;
      req_tready   = (state_ff == ST_IDLE) & ~rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in    = req_tdata[X_W-1:0];
               y_in    = req_tdata[X_W+Y_W-1:X_W];
               last_in = req_tlast;
               step_in = '0;
               if (full) begin
                  overflow_in = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            alu_cmd.start    = 1'b1;
            alu_cmd.op       = OP_MAC;
            alu_cmd.first    = cur.first;
            alu_cmd.neg      = cur.neg;
            alu_cmd.last_bit = (step_ff <= STEP_SAMPLE_LAST) ? SAMPLE_MSB : SOLVE_MSB;
         end
         ST_WAIT: begin
            if (alu_done) begin
               case (cur.dst)
                  DST_X2:  x2_in  = alu_stat.acc[X2_W-1:0];
                  DST_X3:  x3_in  = alu_stat.acc[X3_W-1:0];
                  DST_X4:  x4_in  = alu_stat.acc[X4_W-1:0];
                  DST_XY:  xy_in  = alu_stat.acc[XY_W-1:0];
                  DST_X2Y: x2y_in = alu_stat.acc[X2Y_W-1:0];
                  DST_DET: det_in = alu_stat.acc;
                  DST_MEM: ram_we = 1'b1;
                  default: ram_we = 1'b0;
               endcase
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_SUMS: begin
            count_in   = count_ff + POINTS_W'(1);
            sum_x_in   = sum_x_ff + SX_W'(x_ff);
            sum_x2_in  = sum_x2_ff + SX2_W'(x2_ff);
            sum_x3_in  = sum_x3_ff + SX3_W'(x3_ff);
            sum_x4_in  = sum_x4_ff + SX4_W'(x4_ff);
            sum_y_in   = sum_y_ff + SY_W'(y_ff);
            sum_xy_in  = sum_xy_ff + SXY_W'(xy_ff);
            sum_x2y_in = sum_x2y_ff + SX2Y_W'(x2y_ff);
         end
         ST_CHECK: begin
            singular_in = (det_ff == '0);
            didx_in     = '0;
         end
         ST_DLOAD: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = OP_DIV;
         end
         ST_DWAIT: begin
            if (alu_done) begin
               case (didx_ff)
                  2'd0:    coef0_in = coef_val;
                  2'd1:    coef1_in = coef_val;
                  default: coef2_in = coef_val;
               endcase
               sat_in  = sat_ff | coef_sat;
               didx_in = didx_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {(RSP_DATA_W - 3*COEF_W - POINTS_W - STATUS_W)'(0),
                            status, count_ff, out2, out1, out0};
            count_in     = '0;
            overflow_in  = 1'b0;
            singular_in  = 1'b0;
            sat_in       = 1'b0;
            sum_x_in     = '0;
            sum_x2_in    = '0;
            sum_x3_in    = '0;
            sum_x4_in    = '0;
            sum_y_in     = '0;
            sum_xy_in    = '0;
            sum_x2y_in   = '0;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         singular_ff  <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_x_ff     <= '0;
         sum_x2_ff    <= '0;
         sum_x3_ff    <= '0;
         sum_x4_ff    <= '0;
         sum_y_ff     <= '0;
         sum_xy_ff    <= '0;
         sum_x2y_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         singular_ff  <= singular_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_x_ff     <= sum_x_in;
         sum_x2_ff    <= sum_x2_in;
         sum_x3_ff    <= sum_x3_in;
         sum_x4_ff    <= sum_x4_in;
         sum_y_ff     <= sum_y_in;
         sum_xy_ff    <= sum_xy_in;
         sum_x2y_ff   <= sum_x2y_in;
      end
      step_ff     <= step_in;
      didx_ff     <= didx_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      last_ff     <= last_in;
      x2_ff       <= x2_in;
      x3_ff       <= x3_in;
      x4_ff       <= x4_in;
      xy_ff       <= xy_in;
      x2y_ff      <= x2y_in;
      det_ff      <= det_in;
      coef0_ff    <= coef0_in;
      coef1_ff    <= coef1_in;
      coef2_ff    <= coef2_in;
      rsp_data_ff <= rsp_data_in;
   end

   qlsf_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur.waddr),
      .wr_data (alu_stat.acc),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   qlsf_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opa   (opa),
      .opb   (opb),
      .opd   (opd),
      .stat  (alu_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/qlsf_ram.sv =====
module qlsf_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [qlsf_pkg::RAM_AW-1:0]   wr_addr,
   input  logic [qlsf_pkg::WIDE_W-1:0]   wr_data,
   input  logic [qlsf_pkg::RAM_AW-1:0]   rd_addr,
   output logic [qlsf_pkg::WIDE_W-1:0]   rd_data
);
   import qlsf_pkg::*;

   logic [WIDE_W-1:0] mem_ff [RAM_DEPTH];
   logic [WIDE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/qlsf_alu.sv =====
// Shared bit-serial unit: signed multiply-accumulate one multiplier bit per
// cycle, and a restoring divide one quotient bit per cycle with rounding.
module qlsf_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  qlsf_pkg::alu_cmd_type       cmd,
   input  logic [qlsf_pkg::WIDE_W-1:0] opa,
   input  logic [qlsf_pkg::MUL_W-1:0]  opb,
   input  logic [qlsf_pkg::WIDE_W-1:0] opd,
   output qlsf_pkg::alu_stat_type      stat
);
   import qlsf_pkg::*;

   alu_state_type     state_ff, state_in;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [WIDE_W-1:0] mcand_ff, mcand_in;
   logic [MUL_W-1:0]  mplier_ff, mplier_in;
   logic [WIDE_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  last_bit_ff, last_bit_in;
   logic              neg_ff, neg_in;
   logic              rnd_ff, rnd_in;

   logic [WIDE_W-1:0] add_x, add_y, rem_shift;
   logic              add_sub, mac_last, qbit;
   logic [WIDE_W:0]   add_sum;

   assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                    + (WIDE_W+1)'(add_sub);
   assign mac_last  = (cnt_ff == last_bit_ff);
   assign rem_shift = {acc_ff[WIDE_W-2:0], mcand_ff[WIDE_W-1]};
   assign qbit      = add_sum[WIDE_W];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         AL_IDLE: begin
            if (cmd.start) begin
               state_in = (cmd.op == OP_MAC) ? AL_MAC : AL_ABSN;
            end
         end
         AL_MAC:  if (mac_last) state_in = AL_IDLE;
         AL_ABSN: state_in = AL_ABSD;
         AL_ABSD: state_in = AL_DIV;
         AL_DIV:  if (cnt_ff == CNT_W'(WIDE_W - 1)) state_in = AL_RND;
         AL_RND:  state_in = AL_INC;
         AL_INC:  state_in = AL_IDLE;
         default: state_in = AL_IDLE;
      endcase
   end

   always_comb begin
      acc_in      = acc_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      div_in      = div_ff;
      cnt_in      = cnt_ff;
      last_bit_in = last_bit_ff;
      neg_in      = neg_ff;
      rnd_in      = rnd_ff;
      add_x       = acc_ff;
      add_y       = mcand_ff;
      add_sub     = 1'b0;
      case (state_ff)
         AL_IDLE: begin
            if (cmd.start) begin
               mcand_in    = opa;
               mplier_in   = opb;
               div_in      = opd;
               cnt_in      = '0;
               last_bit_in = cmd.last_bit;
               if (cmd.op == OP_MAC) begin
                  neg_in = cmd.neg;
                  if (cmd.first) begin
                     acc_in = '0;
                  end
               end else begin
                  neg_in = opa[WIDE_W-1] ^ opd[WIDE_W-1];
               end
            end
         end
         AL_MAC: begin
            // The top multiplier bit carries negative weight.
            add_sub = neg_ff ^ mac_last;
            if (mplier_ff[0]) begin
               acc_in = add_sum[WIDE_W-1:0];
            end
            mcand_in  = {mcand_ff[WIDE_W-2:0], 1'b0};
            mplier_in = {mplier_ff[MUL_W-1], mplier_ff[MUL_W-1:1]};
            cnt_in    = cnt_ff + CNT_W'(1);
         end
         AL_ABSN: begin
            add_x   = '0;
            add_sub = 1'b1;
            if (mcand_ff[WIDE_W-1]) begin
               mcand_in = add_sum[WIDE_W-1:0];
            end
            acc_in = '0;
         end
         AL_ABSD: begin
            add_x   = '0;
            add_y   = div_ff;
            add_sub = 1'b1;
            if (div_ff[WIDE_W-1]) begin
               div_in = add_sum[WIDE_W-1:0];
            end
         end
         AL_DIV: begin
            add_x    = rem_shift;
            add_y    = div_ff;
            add_sub  = 1'b1;
            acc_in   = qbit ? add_sum[WIDE_W-1:0] : rem_shift;
            mcand_in = {mcand_ff[WIDE_W-2:0], qbit};
            cnt_in   = cnt_ff + CNT_W'(1);
         end
         AL_RND: begin
            // Round half away from zero: bump when twice the remainder reaches the divisor.
            add_x   = {acc_ff[WIDE_W-2:0], 1'b0};
            add_y   = div_ff;
            add_sub = 1'b1;
            rnd_in  = add_sum[WIDE_W];
         end
         AL_INC: begin
            add_x    = mcand_ff;
            add_y    = WIDE_W'(rnd_ff);
            mcand_in = add_sum[WIDE_W-1:0];
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AL_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      last_bit_ff <= last_bit_in;
      neg_ff      <= neg_in;
      rnd_ff      <= rnd_in;
   end

   assign stat.busy = (state_ff != AL_IDLE);
   assign stat.qneg = neg_ff;
   assign stat.acc  = acc_ff;
   assign stat.quo  = mcand_ff;

endmodule
